[src/mip_pkg.sv]
// ----------------------------------------------------------------------------
// mip_pkg
// Shared constants and types for the modular inner product block.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int unsigned ValueBitsDefault = 64;
  localparam int unsigned FieldBits        = 64;
  localparam logic [63:0] ModulusReset     = 64'd65537;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_REDUCE,
    BE_MUL,
    BE_ADD
  } be_state_e;

endpackage

[src/modular_inner_product.sv]
// ----------------------------------------------------------------------------
// modular_inner_product
// Streaming dot product of vector elements and weights modulo a modulus.
// ----------------------------------------------------------------------------
// In the back end a request passes through one bit-serial pass reducing both
// operands and the running sum, one bit-serial pass for the modular multiply
// and one add; a two-entry queue in front takes requests while the back end
// works. A request with last set delivers the sum and clears it. Write cfg
// only while idle.
module modular_inner_product #(
  parameter int unsigned VALUE_BITS = mip_pkg::ValueBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [mip_pkg::FieldBits-1:0] vector_element_i,
  input  logic [mip_pkg::FieldBits-1:0] weight_i,
  input  logic                          last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [mip_pkg::FieldBits-1:0] dot_product_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mip_pkg::FieldBits-1:0] cfg_data_i
);

  logic [VALUE_BITS-1:0] mod_q, a, b, res;
  logic                  qv, take, lst, rv;

  assign cfg_ready_o   = 1'b1;
  assign empty         = !rv;
  assign dot_product_o = mip_pkg::FieldBits'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= mip_pkg::ModulusReset[VALUE_BITS-1:0];
    else if (cfg_valid_i && cfg_ready_o) mod_q <= cfg_data_i[VALUE_BITS-1:0];
  end

  mip_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full, .vector_element_i, .weight_i, .last_i,
    .req_valid_o(qv), .req_take_i(take), .req_a_o(a), .req_b_o(b), .req_last_o(lst)
  );

  mip_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i, .rst_ni, .mod_i(mod_q), .req_valid_i(qv), .req_take_o(take),
    .req_a_i(a), .req_b_i(b), .req_last_i(lst),
    .res_valid_o(rv), .res_take_i(pop), .res_o(res)
  );

endmodule

[src/mip_front.sv]
// ----------------------------------------------------------------------------
// mip_front
// Accepts requests, masks operands and queues them for the back end.
// ----------------------------------------------------------------------------
module mip_front #(
  parameter int unsigned VALUE_BITS = mip_pkg::ValueBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [mip_pkg::FieldBits-1:0] vector_element_i,
  input  logic [mip_pkg::FieldBits-1:0] weight_i,
  input  logic                          last_i,
  output logic                          req_valid_o,
  input  logic                          req_take_i,
  output logic [VALUE_BITS-1:0]         req_a_o,
  output logic [VALUE_BITS-1:0]         req_b_o,
  output logic                          req_last_o
);

  localparam int unsigned Depth = mip_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [VALUE_BITS-1:0] a_mem [Depth];
  logic [VALUE_BITS-1:0] b_mem [Depth];
  logic [Depth-1:0]      l_mem;
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [PtrW:0]         cnt_q;
  logic                  wr_en, rd_en;

  assign full        = (cnt_q == (PtrW+1)'(Depth));
  assign wr_en       = push && !full;
  assign req_valid_o = (cnt_q != '0);
  assign rd_en       = req_valid_o && req_take_i;
  assign req_a_o     = a_mem[rd_q];
  assign req_b_o     = b_mem[rd_q];
  assign req_last_o  = l_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      a_mem[wr_q] <= vector_element_i[VALUE_BITS-1:0];
      b_mem[wr_q] <= weight_i[VALUE_BITS-1:0];
      l_mem[wr_q] <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

endmodule

[src/mip_back.sv]
// ----------------------------------------------------------------------------
// mip_back
// Bit-serial modular reduce, multiply and accumulate, with a result register.
// ----------------------------------------------------------------------------
module mip_back #(
  parameter int unsigned VALUE_BITS = mip_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [VALUE_BITS-1:0] mod_i,
  input  logic                  req_valid_i,
  output logic                  req_take_o,
  input  logic [VALUE_BITS-1:0] req_a_i,
  input  logic [VALUE_BITS-1:0] req_b_i,
  input  logic                  req_last_i,
  output logic                  res_valid_o,
  input  logic                  res_take_i,
  output logic [VALUE_BITS-1:0] res_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  mip_pkg::be_state_e state_q, state_d;
  logic [VALUE_BITS-1:0] a_q, a_d, b_q, b_d, ra_q, ra_d, rb_q, rb_d;
  logic [VALUE_BITS-1:0] rs_q, rs_d, acc_q, acc_d, sum_q, sum_d, res_q, res_d;
  logic                  last_q, last_d, rv_q, rv_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  mod_ok;

  // remainder step: r = 2r + bit, subtract m if it reaches m
  function automatic logic [VALUE_BITS-1:0] rstep(
    input logic [VALUE_BITS-1:0] r, input logic bit_in, input logic [VALUE_BITS-1:0] m
  );
    logic [VALUE_BITS:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[VALUE_BITS-1:0];
  endfunction

  // x + y mod m, x and y below m
  function automatic logic [VALUE_BITS-1:0] addm(
    input logic [VALUE_BITS-1:0] x, input logic [VALUE_BITS-1:0] y,
    input logic [VALUE_BITS-1:0] m
  );
    logic [VALUE_BITS:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[VALUE_BITS-1:0];
  endfunction

  assign mod_ok      = (mod_i > VALUE_BITS'(1));
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    a_d = a_q; b_d = b_q; ra_d = ra_q; rb_d = rb_q; rs_d = rs_q;
    acc_d = acc_q; sum_d = sum_q; res_d = res_q; last_d = last_q; cnt_d = cnt_q;
    rv_d       = rv_q && !res_take_i;
    req_take_o = 1'b0;
    case (state_q)
      mip_pkg::BE_IDLE: begin
        if (req_valid_i && !(last_q && rv_q && !res_take_i)) begin
          req_take_o = 1'b1;
          a_d = req_a_i; b_d = req_b_i; last_d = req_last_i;
          ra_d = '0; rb_d = '0; rs_d = '0;
          cnt_d = CntW'(VALUE_BITS);
          state_d = mip_pkg::BE_REDUCE;
        end
      end
      mip_pkg::BE_REDUCE: begin
        ra_d = rstep(ra_q, a_q[VALUE_BITS-1], mod_i);
        rb_d = rstep(rb_q, b_q[VALUE_BITS-1], mod_i);
        rs_d = rstep(rs_q, sum_q[VALUE_BITS-1], mod_i);
        a_d = a_q << 1; b_d = b_q << 1; sum_d = sum_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          acc_d = '0;
          cnt_d = CntW'(VALUE_BITS);
          state_d = mip_pkg::BE_MUL;
        end
      end
      mip_pkg::BE_MUL: begin
        acc_d = addm(acc_q, acc_q, mod_i);
        if (rb_q[VALUE_BITS-1]) acc_d = addm(acc_d, ra_q, mod_i);
        rb_d = rb_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = mip_pkg::BE_ADD;
      end
      mip_pkg::BE_ADD: begin
        if (!(last_q && rv_d)) begin
          sum_d = mod_ok ? addm(rs_q, acc_q, mod_i) : '0;
          if (last_q) begin
            res_d = sum_d;
            rv_d  = 1'b1;
            sum_d = '0;
          end
          state_d = mip_pkg::BE_IDLE;
        end
      end
      default: state_d = mip_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; ra_q <= ra_d; rb_q <= rb_d; rs_q <= rs_d;
    acc_q <= acc_d; res_q <= res_d; cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mip_pkg::BE_IDLE;
      sum_q   <= '0;
      last_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
      rv_q    <= rv_d;
    end
  end

endmodule

[src/mip_checker.sv]
// ----------------------------------------------------------------------------
// mip_checker
// Port-level checks on the modular inner product.
// ----------------------------------------------------------------------------
module mip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [63:0] dot_product_o,
  input logic        push,
  input logic        full
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(dot_product_o)) else $error("result lost");

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result after reset");

  a_no_full_rst: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("full after reset");

  // the queue cannot fill without a request
  a_no_spont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full && !push |=> !full)
    else $error("spurious full");

endmodule

bind modular_inner_product mip_checker u_mip_checker (
  .clk_i, .rst_ni, .empty, .pop, .dot_product_o, .push, .full
);

[bench/modular_inner_product_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inner_product_tb
// Streams element/weight pairs through the modular inner product block under
// many moduli (reset value, zero, one, two, small, wide, all ones), with
// random gaps on both queue sides and one long result back-pressure stretch.
// Each dot product is checked against a table value or a local modular accumulator.
// ----------------------------------------------------------------------------
module modular_inner_product_tb;

  localparam logic [63:0] AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TopBit    = 64'h8000_0000_0000_0000;
  localparam int unsigned DrainWait = 450;
  localparam int unsigned NumItems  = 1300;

  typedef struct {
    bit          wr_mod;
    logic [63:0] mod_val;
    logic [63:0] elem;
    logic [63:0] wgt;
    bit          last;
    bit          typed;
    logic [63:0] dot;
  } pair_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] vector_element_i = '0;
  logic [63:0] weight_i = '0;
  logic        last_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] dot_product_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  logic [63:0] dot_q[$];
  logic [63:0] modulus_shadow = mip_pkg::ModulusReset;
  logic [63:0] sum_shadow = '0;
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  bit          hold_go = 1'b0;
  bit          quiet = 1'b0;

  pair_row_t rows[] = '{
    '{0, 0, 0, 0, 1, 1, 0},
    '{0, 0, AllOnes, AllOnes, 1, 1, 0},
    '{0, 0, 1, 1, 1, 1, 1},
    '{0, 0, 65536, 65536, 1, 1, 1},
    '{0, 0, 65537, 5, 1, 1, 0},
    '{0, 0, 3, 4, 0, 0, 0},
    '{0, 0, 5, 6, 1, 0, 0},
    '{0, 0, 7, 8, 0, 0, 0},
    '{1, 1000003, 9, 10, 1, 0, 0},
    '{1, 0, AllOnes, 123, 0, 0, 0},
    '{0, 0, 5, 7, 1, 1, 0},
    '{1, 1, 3, 3, 1, 1, 0},
    '{1, AllOnes, AllOnes - 1, AllOnes - 1, 1, 1, 1},
    '{0, 0, AllOnes, 7, 1, 1, 0},
    '{1, 2, 3, 5, 1, 1, 1},
    '{0, 0, 2, AllOnes, 1, 1, 0},
    '{1, AllOnes, TopBit, TopBit, 0, 0, 0},
    '{0, 0, AllOnes - 1, AllOnes - 1, 1, 0, 0},
    '{1, 64'hFFFF_FFFF_FFFF_FFC5, AllOnes, 64'h1234_5678_9ABC_DEF0, 0, 0, 0},
    '{0, 0, 64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC4, 1, 0, 0}
  };

  modular_inner_product u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .vector_element_i(vector_element_i),
    .weight_i        (weight_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .dot_product_o   (dot_product_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mod_accumulate(input logic [63:0] elem,
                                                 input logic [63:0] wgt);
    logic [63:0]  a;
    logic [63:0]  b;
    logic [127:0] prod;
    logic [64:0]  s;
    if (modulus_shadow < 2) return '0;
    a    = elem % modulus_shadow;
    b    = wgt % modulus_shadow;
    prod = ({64'd0, a} * {64'd0, b}) % {64'd0, modulus_shadow};
    s    = {1'b0, sum_shadow % modulus_shadow} + {1'b0, prod[63:0]};
    if (s >= {1'b0, modulus_shadow}) s = s - {1'b0, modulus_shadow};
    return s[63:0];
  endfunction

  function automatic int unsigned gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [63:0] rand_val(input logic [63:0] m);
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 15));
      1: return AllOnes - $urandom_range(0, 3);
      2: return (m < 2) ? {$urandom, $urandom} : {$urandom, $urandom} % m;
      3: return (m < 2) ? 64'd0 : m - $urandom_range(1, 2);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_idle();
    while (dot_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    modulus_shadow = value;
  endtask

  // push held high across back-to-back requests; lowered for a gap or by end_stream
  task automatic send_pair(input logic [63:0] elem, input logic [63:0] wgt,
                           input bit last, input bit typed, input logic [63:0] dot);
    int unsigned gap;
    logic [63:0] nxt;
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    vector_element_i <= elem;
    weight_i         <= wgt;
    last_i           <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    nxt = mod_accumulate(elem, wgt);
    sent++;
    if (last) begin
      dot_q = {dot_q, (typed ? dot : nxt)};
      sum_shadow = '0;
    end else begin
      sum_shadow = nxt;
    end
  endtask

  task automatic end_stream();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned stall;
    int unsigned hold;
    logic [63:0] want;
    stall = 0;
    hold  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (dot_q.size() == 0) begin
          $error("unexpected dot_product %h", dot_product_o);
          mismatches++;
        end else begin
          want = dot_q.pop_front();
          if (dot_product_o !== want) begin
            $error("dot_product expected %h actual %h", want, dot_product_o);
            mismatches++;
          end
        end
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold    = 3000;
      end
      if (hold != 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop   <= 1'b1;
        stall = gap_len();
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned len;
    logic [63:0] m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].wr_mod) begin
        end_stream();
        wait_idle();
        write_modulus(rows[i].mod_val);
      end
      send_pair(rows[i].elem, rows[i].wgt, rows[i].last, rows[i].typed, rows[i].dot);
    end

    phase = 0;
    while (sent < NumItems) begin
      end_stream();
      wait_idle();
      case ($urandom_range(0, 9))
        0: m = 64'($urandom_range(0, 1));
        1: m = 64'($urandom_range(2, 20));
        2: m = 64'($urandom_range(2, 65537));
        3: m = AllOnes - $urandom_range(0, 64);
        4: m = TopBit >> $urandom_range(0, 62);
        5: m = mip_pkg::ModulusReset;
        default: m = {$urandom, $urandom};
      endcase
      write_modulus(m);
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 3) hold_go = 1'b1;
      n = $urandom_range(20, 60);
      while (n != 0) begin
        len = $urandom_range(1, 8);
        while (len != 0 && n != 0) begin
          // occasionally leave the vector open across the modulus change
          send_pair(rand_val(m), rand_val(m),
                    (len == 1 && (n > 1 || $urandom_range(0, 3) != 0)), 1'b0, '0);
          len--;
          n--;
        end
      end
      phase++;
    end

    end_stream();
    while (dot_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
